[rtl/rwla_pkg.sv]
// Shared types and codes for the readers-writers lock arbiter.
`default_nettype none

package rwla_pkg;

    localparam int ID_W    = 8;
    localparam int MODE_W  = 2;
    localparam int REPLY_W = 2;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DONE  = 2'd2;

    // Reply codes
    localparam logic [REPLY_W-1:0] REPLY_WORK = 2'd0;
    localparam logic [REPLY_W-1:0] REPLY_WAIT = 2'd1;
    localparam logic [REPLY_W-1:0] REPLY_FULL = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_SRCH_W,
        ST_SRCH_R,
        ST_PLAN,
        ST_REPLY,
        ST_BCAST,
        ST_GRANT
    } state_t;

    // List update commands
    typedef struct packed {
        logic push;
        logic remove;
    } list_ctl_t;

endpackage

`default_nettype wire

[rtl/rwla_list.sv]
// Ordered id list: append at tail, remove at index with compaction, indexed read.
`default_nettype none

module rwla_list #(
    parameter int DEPTH = 8
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire  rwla_pkg::list_ctl_t             ctl,
    input  wire  [rwla_pkg::ID_W-1:0]             push_data,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] idx,
    output logic [rwla_pkg::ID_W-1:0]             rd_data,
    output logic [rwla_pkg::ID_W-1:0]             head,
    output logic [$clog2(DEPTH + 1)-1:0]          count,
    output logic                                  full
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [rwla_pkg::ID_W-1:0] entry_reg [DEPTH];
    logic [CNT_W-1:0]          count_reg;

    // Entry storage: tail append, or close the gap above the removed index
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            entry_reg[count_reg[IDX_W-1:0]] <= push_data;
        end
        else if (ctl.remove)
        begin
            for (int j = 0; j < DEPTH - 1; j++)
            begin
                if (IDX_W'(j) >= idx)
                begin
                    entry_reg[j] <= entry_reg[j + 1];
                end
            end
        end
    end

    // Fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.push)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
        else if (ctl.remove)
        begin
            count_reg <= count_reg - CNT_W'(1);
        end
    end

    assign rd_data = entry_reg[idx];
    assign head    = entry_reg[0];
    assign count   = count_reg;
    assign full    = (count_reg == CNT_W'(DEPTH));

endmodule

`default_nettype wire

[rtl/readers_writers_lock_arbiter_core.sv]
// Top level: writer-priority readers-writers lock server with a message sequencer.
// Sequence: after the request transfer an apply state and a plan state, then the reply,
//   broadcast and grant states, each sending its message or passing on with nothing to send;
//   a completion first compares writer queue entries, then reader list entries, until a match.
// Throughput: one request at a time, taken once its last message is registered; msg_ready low stalls it.
// Reset clears list counts, paused/active flags and the sequencer; entries are not cleared.
`default_nettype none

module readers_writers_lock_arbiter_core #(
    parameter int MAX_READERS = 8,
    parameter int MAX_WRITERS = 2
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                req_valid,
    output logic                               req_ready,
    input  wire  [rwla_pkg::MODE_W-1:0]        mode,
    input  wire  [rwla_pkg::ID_W-1:0]          requester,
    output logic                               msg_valid,
    input  wire                                msg_ready,
    output logic [rwla_pkg::ID_W-1:0]          destination,
    output logic [rwla_pkg::REPLY_W-1:0]       reply,
    output logic                               last
);

    localparam int RIDX_W = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
    localparam int WIDX_W = (MAX_WRITERS > 1) ? $clog2(MAX_WRITERS) : 1;
    localparam int RCNT_W = $clog2(MAX_READERS + 1);
    localparam int WCNT_W = $clog2(MAX_WRITERS + 1);
    localparam int IDX_W  = (RCNT_W > WCNT_W) ? RCNT_W : WCNT_W;

    rwla_pkg::state_t              state_reg, state_next;
    logic [rwla_pkg::MODE_W-1:0]   mode_reg, mode_next;
    logic [rwla_pkg::ID_W-1:0]     id_reg, id_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic                          pend_reg, pend_next;
    logic [rwla_pkg::REPLY_W-1:0]  pend_reply_reg, pend_reply_next;
    logic                          bcast_reg, bcast_next;
    logic [rwla_pkg::REPLY_W-1:0]  bc_reply_reg, bc_reply_next;
    logic                          grant_reg, grant_next;
    logic                          paused_reg, paused_next;
    logic                          active_reg, active_next;

    logic                          msg_valid_reg;
    logic [rwla_pkg::ID_W-1:0]     dest_reg;
    logic [rwla_pkg::REPLY_W-1:0]  reply_reg;
    logic                          last_reg;

    // List interfaces
    rwla_pkg::list_ctl_t           r_ctl, w_ctl;
    logic [rwla_pkg::ID_W-1:0]     r_rd_data, r_head, w_rd_data, w_head;
    logic [RCNT_W-1:0]             r_count;
    logic [WCNT_W-1:0]             w_count;
    logic                          r_full, w_full;

    // Shared compare unit and sequencer helpers
    logic [rwla_pkg::ID_W-1:0]     cmp_entry;
    logic                          hit;
    logic [IDX_W-1:0]              idx_inc;
    logic [IDX_W-1:0]              r_count_ext, w_count_ext;
    logic                          slot_free;
    logic                          emit;
    logic [rwla_pkg::ID_W-1:0]     e_dest;
    logic [rwla_pkg::REPLY_W-1:0]  e_reply;
    logic                          e_last;

    rwla_list #(
        .DEPTH (MAX_READERS)
    ) u_readers (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (r_ctl),
        .push_data (id_reg),
        .idx       (idx_reg[RIDX_W-1:0]),
        .rd_data   (r_rd_data),
        .head      (r_head),
        .count     (r_count),
        .full      (r_full)
    );

    rwla_list #(
        .DEPTH (MAX_WRITERS)
    ) u_writers (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (w_ctl),
        .push_data (id_reg),
        .idx       (idx_reg[WIDX_W-1:0]),
        .rd_data   (w_rd_data),
        .head      (w_head),
        .count     (w_count),
        .full      (w_full)
    );

    assign cmp_entry   = (state_reg == rwla_pkg::ST_SRCH_W) ? w_rd_data : r_rd_data;
    assign hit         = (cmp_entry == id_reg);
    assign idx_inc     = idx_reg + IDX_W'(1);
    assign r_count_ext = IDX_W'(r_count);
    assign w_count_ext = IDX_W'(w_count);
    assign slot_free   = !msg_valid_reg || msg_ready;

    // Sequencer: next state, list commands and message emission
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        id_next         = id_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        pend_reply_next = pend_reply_reg;
        bcast_next      = bcast_reg;
        bc_reply_next   = bc_reply_reg;
        grant_next      = grant_reg;
        paused_next     = paused_reg;
        active_next     = active_reg;
        r_ctl           = '0;
        w_ctl           = '0;
        emit            = 1'b0;
        e_dest          = id_reg;
        e_reply         = pend_reply_reg;
        e_last          = 1'b0;

        unique case (state_reg)
            rwla_pkg::ST_IDLE:
            begin
                idx_next = '0;
                if (req_valid)
                begin
                    mode_next  = mode;
                    id_next    = requester;
                    pend_next  = 1'b0;
                    state_next = rwla_pkg::ST_APPLY;
                end
            end

            // Store the request and set up the direct reply, or start the search for a completion
            rwla_pkg::ST_APPLY:
            begin
                priority if (mode_reg == rwla_pkg::MODE_READ)
                begin
                    pend_next = 1'b1;
                    if (r_full)
                    begin
                        pend_reply_next = rwla_pkg::REPLY_FULL;
                    end
                    else
                    begin
                        r_ctl.push      = 1'b1;
                        pend_reply_next = (w_count == '0) ? rwla_pkg::REPLY_WORK
                                                          : rwla_pkg::REPLY_WAIT;
                    end
                    state_next = rwla_pkg::ST_PLAN;
                end
                else if (mode_reg == rwla_pkg::MODE_WRITE)
                begin
                    pend_next = 1'b1;
                    if (w_full)
                    begin
                        pend_reply_next = rwla_pkg::REPLY_FULL;
                    end
                    else
                    begin
                        w_ctl.push      = 1'b1;
                        pend_reply_next = rwla_pkg::REPLY_WAIT;
                    end
                    state_next = rwla_pkg::ST_PLAN;
                end
                else if (mode_reg == rwla_pkg::MODE_DONE)
                begin
                    idx_next   = '0;
                    state_next = rwla_pkg::ST_SRCH_W;
                end
                else
                begin
                    state_next = rwla_pkg::ST_PLAN;
                end
            end

            // Scan writer queue for the completing id
            rwla_pkg::ST_SRCH_W:
            begin
                if (idx_reg >= w_count_ext)
                begin
                    idx_next   = '0;
                    state_next = rwla_pkg::ST_SRCH_R;
                end
                else if (hit)
                begin
                    w_ctl.remove = 1'b1;
                    active_next  = 1'b0;
                    state_next   = rwla_pkg::ST_PLAN;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            // Scan reader list for the completing id
            rwla_pkg::ST_SRCH_R:
            begin
                if (idx_reg >= r_count_ext)
                begin
                    state_next = rwla_pkg::ST_PLAN;
                end
                else if (hit)
                begin
                    r_ctl.remove = 1'b1;
                    state_next   = rwla_pkg::ST_PLAN;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            // Scheduling decision on the updated lists
            rwla_pkg::ST_PLAN:
            begin
                idx_next   = '0;
                bcast_next = 1'b0;
                grant_next = 1'b0;
                if (w_count == '0)
                begin
                    if (paused_reg)
                    begin
                        bcast_next    = (r_count != '0);
                        bc_reply_next = rwla_pkg::REPLY_WORK;
                        paused_next   = 1'b0;
                    end
                end
                else if (!active_reg)
                begin
                    if (!paused_reg)
                    begin
                        bcast_next    = (r_count != '0);
                        bc_reply_next = rwla_pkg::REPLY_WAIT;
                        paused_next   = 1'b1;
                    end
                    grant_next  = 1'b1;
                    active_next = 1'b1;
                end
                state_next = rwla_pkg::ST_REPLY;
            end

            rwla_pkg::ST_REPLY:
            begin
                if (!pend_reg)
                begin
                    state_next = rwla_pkg::ST_BCAST;
                end
                else if (slot_free)
                begin
                    emit       = 1'b1;
                    e_dest     = id_reg;
                    e_reply    = pend_reply_reg;
                    e_last     = !bcast_reg && !grant_reg;
                    state_next = e_last ? rwla_pkg::ST_IDLE : rwla_pkg::ST_BCAST;
                end
            end

            // One pause/resume transfer per listed reader
            rwla_pkg::ST_BCAST:
            begin
                if (!bcast_reg)
                begin
                    state_next = rwla_pkg::ST_GRANT;
                end
                else if (slot_free)
                begin
                    emit    = 1'b1;
                    e_dest  = r_rd_data;
                    e_reply = bc_reply_reg;
                    e_last  = (idx_inc == r_count_ext) && !grant_reg;
                    if (idx_inc == r_count_ext)
                    begin
                        state_next = grant_reg ? rwla_pkg::ST_GRANT : rwla_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
            end

            rwla_pkg::ST_GRANT:
            begin
                if (!grant_reg)
                begin
                    state_next = rwla_pkg::ST_IDLE;
                end
                else if (slot_free)
                begin
                    emit       = 1'b1;
                    e_dest     = w_head;
                    e_reply    = rwla_pkg::REPLY_WORK;
                    e_last     = 1'b1;
                    state_next = rwla_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rwla_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rwla_pkg::ST_IDLE;
            pend_reg      <= 1'b0;
            bcast_reg     <= 1'b0;
            grant_reg     <= 1'b0;
            paused_reg    <= 1'b0;
            active_reg    <= 1'b0;
            msg_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pend_reg   <= pend_next;
            bcast_reg  <= bcast_next;
            grant_reg  <= grant_next;
            paused_reg <= paused_next;
            active_reg <= active_next;
            if (emit)
            begin
                msg_valid_reg <= 1'b1;
            end
            else if (msg_ready)
            begin
                msg_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        id_reg         <= id_next;
        idx_reg        <= idx_next;
        pend_reply_reg <= pend_reply_next;
        bc_reply_reg   <= bc_reply_next;
        if (emit)
        begin
            dest_reg  <= e_dest;
            reply_reg <= e_reply;
            last_reg  <= e_last;
        end
    end

    assign req_ready   = (state_reg == rwla_pkg::ST_IDLE);
    assign msg_valid   = msg_valid_reg;
    assign destination = dest_reg;
    assign reply       = reply_reg;
    assign last        = last_reg;

    // Checks
    a_active_has_writer: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (w_count != '0))
        else $error("writer marked active with an empty writer queue");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && e_last) |=> req_ready)
        else $error("final transfer of an item did not return to idle");

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while previous one still in progress");

endmodule

`default_nettype wire

[test/rwla_lock_checker.sv]
// Checker for the lock arbiter: predicts the message stream and compares every transfer.
`timescale 1ns / 1ps

module rwla_lock_checker #(
    parameter int MAX_READERS = 8,
    parameter int MAX_WRITERS = 2
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          req_valid,
    input  wire                          req_ready,
    input  wire  [rwla_pkg::MODE_W-1:0]  mode,
    input  wire  [rwla_pkg::ID_W-1:0]    requester,
    input  wire                          msg_valid,
    input  wire                          msg_ready,
    input  wire  [rwla_pkg::ID_W-1:0]    destination,
    input  wire  [rwla_pkg::REPLY_W-1:0] reply,
    input  wire                          last,
    output int                           fail_count,
    output int                           outstanding
);

    typedef struct packed {
        logic [rwla_pkg::ID_W-1:0]    dest;
        logic [rwla_pkg::REPLY_W-1:0] code;
        logic                         fin;
    } lock_msg_t;

    // Shadow copy of the lock state
    logic [rwla_pkg::ID_W-1:0] reader_ids [MAX_READERS];
    logic [rwla_pkg::ID_W-1:0] writer_ids [MAX_WRITERS];
    int              reader_cnt;
    int              writer_cnt;
    logic            paused;
    logic            writing;

    // Messages still owed by the block, oldest first
    lock_msg_t       lock_msgs_q [$];

    initial fail_count = 0;
    initial outstanding = 0;

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // Apply one request to the shadow state and queue the messages it causes
    task automatic serve_request(input logic [rwla_pkg::MODE_W-1:0] m,
                                 input logic [rwla_pkg::ID_W-1:0] id);
        lock_msg_t batch [$];
        lock_msg_t cur;
        int        hit;
        int        i;
        hit = -1;
        if (m == rwla_pkg::MODE_READ)
        begin
            if (reader_cnt >= MAX_READERS)
            begin
                batch.push_back({id, rwla_pkg::REPLY_FULL, 1'b0});
            end
            else
            begin
                reader_ids[reader_cnt] = id;
                reader_cnt++;
                batch.push_back({id, (writer_cnt == 0) ? rwla_pkg::REPLY_WORK
                                                       : rwla_pkg::REPLY_WAIT, 1'b0});
            end
        end
        else if (m == rwla_pkg::MODE_WRITE)
        begin
            if (writer_cnt >= MAX_WRITERS)
            begin
                batch.push_back({id, rwla_pkg::REPLY_FULL, 1'b0});
            end
            else
            begin
                writer_ids[writer_cnt] = id;
                writer_cnt++;
                batch.push_back({id, rwla_pkg::REPLY_WAIT, 1'b0});
            end
        end
        else if (m == rwla_pkg::MODE_DONE)
        begin
            // writer queue first; any matching writer ends the active write
            for (i = 0; i < writer_cnt; i++)
            begin
                if (hit < 0 && writer_ids[i] == id)
                    hit = i;
            end
            if (hit >= 0)
            begin
                for (i = hit; i < writer_cnt - 1; i++)
                    writer_ids[i] = writer_ids[i + 1];
                writer_cnt--;
                writing = 1'b0;
            end
            else
            begin
                for (i = 0; i < reader_cnt; i++)
                begin
                    if (hit < 0 && reader_ids[i] == id)
                        hit = i;
                end
                if (hit >= 0)
                begin
                    for (i = hit; i < reader_cnt - 1; i++)
                        reader_ids[i] = reader_ids[i + 1];
                    reader_cnt--;
                end
            end
        end

        // Scheduling: resume readers when no writer waits, else, with no active write, pause them and grant
        if (writer_cnt == 0)
        begin
            if (paused)
            begin
                for (i = 0; i < reader_cnt; i++)
                    batch.push_back({reader_ids[i], rwla_pkg::REPLY_WORK, 1'b0});
                paused = 1'b0;
            end
        end
        else if (!writing)
        begin
            if (!paused)
            begin
                for (i = 0; i < reader_cnt; i++)
                    batch.push_back({reader_ids[i], rwla_pkg::REPLY_WAIT, 1'b0});
                paused = 1'b1;
            end
            batch.push_back({writer_ids[0], rwla_pkg::REPLY_WORK, 1'b0});
            writing = 1'b1;
        end

        for (i = 0; i < batch.size(); i++)
        begin
            cur = batch[i];
            if (i == batch.size() - 1)
                cur.fin = 1'b1;
            lock_msgs_q.push_back(cur);
        end
    endtask

    // Compare message transfers first, then predict from a request transfer
    always @(posedge clk or negedge rst_n)
    begin
        lock_msg_t want;
        if (!rst_n)
        begin
            reader_cnt = 0;
            writer_cnt = 0;
            paused = 1'b0;
            writing = 1'b0;
            lock_msgs_q.delete();
            outstanding = 0;
        end
        else
        begin
            if (msg_valid && msg_ready)
            begin
                if (lock_msgs_q.size() == 0)
                begin
                    flag_mismatch("unexpected message to destination", destination, -1);
                end
                else
                begin
                    want = lock_msgs_q.pop_front();
                    if (destination !== want.dest)
                        flag_mismatch("destination", destination, want.dest);
                    if (reply !== want.code)
                        flag_mismatch("reply", reply, want.code);
                    if (last !== want.fin)
                        flag_mismatch("last", last, want.fin);
                end
            end
            if (req_valid && req_ready)
                serve_request(mode, requester);
            outstanding = lock_msgs_q.size();
        end
    end

endmodule

[test/tb_readers_writers_lock_arbiter_core.sv]
// Testbench top: clock, reset, request and message-side traffic, and the final verdict.
`timescale 1ns / 1ps

module tb_readers_writers_lock_arbiter_core;

    // Mode code the block does not define; it must be ignored
    localparam logic [rwla_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 290;
    localparam int CALM_ITEMS   = 40;
    localparam int CHOKE_AT     = 60;
    localparam int CHOKE_CYCLES = 300;
    localparam int DRAIN_CYCLES = 60;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         req_valid = 1'b0;
    logic                         req_ready;
    logic [rwla_pkg::MODE_W-1:0]  mode = rwla_pkg::MODE_READ;
    logic [rwla_pkg::ID_W-1:0]    requester = '0;
    logic                         msg_valid;
    logic                         msg_ready = 1'b0;
    logic [rwla_pkg::ID_W-1:0]    destination;
    logic [rwla_pkg::REPLY_W-1:0] reply;
    logic                         last;

    int                 fail_count;
    int                 outstanding;

    bit                 idle_on = 1'b0;
    bit                 choke_go = 1'b0;
    bit                 choke_done = 1'b0;
    int                 choke_left = 0;
    int                 stall_left = 0;

    // Ids that were requested and not yet completed, as the client side sees them
    logic [rwla_pkg::ID_W-1:0] holders [$];

    readers_writers_lock_arbiter_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .mode        (mode),
        .requester   (requester),
        .msg_valid   (msg_valid),
        .msg_ready   (msg_ready),
        .destination (destination),
        .reply       (reply),
        .last        (last)
    );

    rwla_lock_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .mode        (mode),
        .requester   (requester),
        .msg_valid   (msg_valid),
        .msg_ready   (msg_ready),
        .destination (destination),
        .reply       (reply),
        .last        (last),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Message side: one long hold-off once, random stall bursts while idling is on
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            msg_ready <= 1'b0;
        end
        else if (choke_go && !choke_done)
        begin
            msg_ready <= 1'b0;
            if (choke_left == CHOKE_CYCLES - 1)
                choke_done <= 1'b1;
            choke_left <= choke_left + 1;
        end
        else if (stall_left > 0)
        begin
            msg_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            msg_ready <= 1'b0;
            stall_left <= $urandom_range(0, 17);
        end
        else
        begin
            msg_ready <= 1'b1;
        end
    end

    // Offer one request and hold it until the transfer
    task automatic offer(input logic [rwla_pkg::MODE_W-1:0] m,
                         input logic [rwla_pkg::ID_W-1:0] id);
        int k;
        k = -1;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        req_valid <= 1'b1;
        mode <= m;
        requester <= id;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        if (m == rwla_pkg::MODE_READ || m == rwla_pkg::MODE_WRITE)
        begin
            holders.push_back(id);
        end
        else if (m == rwla_pkg::MODE_DONE)
        begin
            foreach (holders[i])
            begin
                if (k < 0 && holders[i] == id)
                    k = i;
            end
            if (k >= 0)
                holders.delete(k);
        end
    endtask

    // Mostly request/complete pairs on a small id pool, a little noise
    task automatic random_item();
        int                        roll;
        int                        done_pct;
        int                        pick;
        logic [rwla_pkg::ID_W-1:0] id;
        roll = $urandom_range(0, 99);
        done_pct = (holders.size() > 10) ? 60 : 30;
        if ($urandom_range(0, 9) == 0)
            id = rwla_pkg::ID_W'($urandom_range(0, 255));
        else
            id = rwla_pkg::ID_W'($urandom_range(1, 12));
        if (roll < 5)
        begin
            offer((roll < 2) ? MODE_SPARE : rwla_pkg::MODE_DONE, id);
        end
        else if (holders.size() > 0 && roll < 5 + done_pct)
        begin
            pick = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, holders.size() - 1);
            offer(rwla_pkg::MODE_DONE, holders[pick]);
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            offer(rwla_pkg::MODE_WRITE, id);
        end
        else
        begin
            offer(rwla_pkg::MODE_READ, id);
        end
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: id extremes, pause and grant, full lists, odd completions
        offer(rwla_pkg::MODE_READ, 8'd0);
        offer(rwla_pkg::MODE_READ, 8'd255);
        offer(rwla_pkg::MODE_READ, 8'd1);
        offer(rwla_pkg::MODE_WRITE, 8'h80);     // pause all readers, grant writer
        offer(rwla_pkg::MODE_READ, 8'd2);       // held: writer queued
        offer(rwla_pkg::MODE_WRITE, 8'h7F);
        offer(rwla_pkg::MODE_WRITE, 8'd3);      // writer queue full
        offer(rwla_pkg::MODE_DONE, 8'h7F);      // non-head writer done clears the active flag
        offer(rwla_pkg::MODE_DONE, 8'h80);      // queue empty: resume readers
        offer(rwla_pkg::MODE_READ, 8'd4);
        offer(rwla_pkg::MODE_READ, 8'd5);
        offer(rwla_pkg::MODE_READ, 8'd6);
        offer(rwla_pkg::MODE_READ, 8'd7);
        offer(rwla_pkg::MODE_READ, 8'd9);       // reader list full
        offer(rwla_pkg::MODE_DONE, 8'd5);
        offer(rwla_pkg::MODE_READ, 8'd4);       // duplicate id
        offer(rwla_pkg::MODE_DONE, 8'd4);       // removes the first copy only
        offer(rwla_pkg::MODE_DONE, 8'd200);     // unknown id: no message
        offer(MODE_SPARE, 8'hAA);               // undefined mode: ignored
        offer(rwla_pkg::MODE_DONE, 8'd0);
        offer(rwla_pkg::MODE_DONE, 8'd255);

        idle_on <= 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == CHOKE_AT)
                choke_go <= 1'b1;
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                idle_on <= 1'b0;
            random_item();
        end

        @(negedge clk);
        req_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("** readers_writers_lock_arbiter_core: PASSED **");
        else
            $display("** readers_writers_lock_arbiter_core: FAILED **");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1_000_000;
        $display("** readers_writers_lock_arbiter_core: FAILED **");
        $finish;
    end

endmodule
